### rtl/gfc_pkg.sv
// Shared types, constants and the digit extraction function of the gated frequency counter.
package gfc_pkg;

   localparam int COUNT_WIDTH  = 24;
   localparam int GATE_WIDTH   = 16;
   localparam int RAW_WIDTH    = 24;
   localparam int SCALED_WIDTH = 22;
   localparam int SAT_WIDTH    = 17;
   localparam int DIGIT_WIDTH  = 4;
   localparam int DIGIT_COUNT  = 5;
   localparam int VREF_WIDTH   = 8;

   localparam logic [GATE_WIDTH-1:0] GATE_RESET  = GATE_WIDTH'(5000);
   localparam logic [VREF_WIDTH-1:0] VREF_RESET  = 8'hE7;
   localparam logic [VREF_WIDTH-1:0] VREF_BASE   = 8'hE0;
   localparam logic [VREF_WIDTH-1:0] VREF_TOP    = 8'hE9;
   localparam int                    DIGIT_LIMIT = 99999;
   localparam int                    KHZ_LIMIT   = 999;
   localparam int                    VREF_SAT_AT = 18;
   localparam int                    VREF_MIN    = 2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int STAGE_COUNT = DIGIT_COUNT - 1;
   localparam int STAGE_WEIGHT [STAGE_COUNT] = '{10000, 1000, 100, 10};

   typedef struct packed {
      logic tick;
      logic edge_req;
   } req_type;

   typedef struct packed {
      logic                    gate_done;
      logic [RAW_WIDTH-1:0]    raw_count;
      logic [SCALED_WIDTH-1:0] scaled_value;
      logic [DIGIT_WIDTH-1:0]  digit_ten_thousands;
      logic [DIGIT_WIDTH-1:0]  digit_thousands;
      logic [DIGIT_WIDTH-1:0]  digit_hundreds;
      logic [DIGIT_WIDTH-1:0]  digit_tens;
      logic [DIGIT_WIDTH-1:0]  digit_units;
      logic                    khz_unit;
      logic [VREF_WIDTH-1:0]   vref_code;
   } rsp_type;

   // Word passed from the front to the digit pipeline.
   typedef struct packed {
      logic                    gate_done;
      logic [RAW_WIDTH-1:0]    raw_count;
      logic [SCALED_WIDTH-1:0] scaled_value;
      logic [SAT_WIDTH-1:0]    sat_value;
      logic                    khz_unit;
      logic [VREF_WIDTH-1:0]   vref_code;
   } work_type;

   typedef struct packed {
      work_type                                work;
      logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] digits;
      logic [SAT_WIDTH-1:0]                    rem;
   } stage_type;

   typedef struct packed {
      logic [DIGIT_WIDTH-1:0] digit;
      logic [SAT_WIDTH-1:0]   rem;
   } digit_step_type;

   // Peel one decimal digit off rem: nine parallel compares, one subtract.
   function automatic digit_step_type digit_step(input logic [SAT_WIDTH-1:0] rem,
                                                 input int weight);
      digit_step_type res;
      int             sel;
      sel = 0;
      for (int d = 1; d <= 9; d++) begin
         if (32'(rem) >= d * weight) begin
            sel = d;
         end
      end
      res.digit = DIGIT_WIDTH'(sel);
      res.rem   = SAT_WIDTH'(32'(rem) - sel * weight);
      return res;
   endfunction

endpackage

### rtl/gfc_front.sv
// Front end: gate window and edge counters, latched reading and word build.
module gfc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  gfc_pkg::req_type                 item_data,
   output logic                             item_ready,
   input  logic [gfc_pkg::GATE_WIDTH-1:0]   gate_ticks,
   output logic                             word_valid,
   output gfc_pkg::work_type                word_data,
   input  logic                             word_ready
);

   logic [gfc_pkg::GATE_WIDTH-1:0]  tick_ff, tick_in;
   logic [gfc_pkg::COUNT_WIDTH-1:0] edge_ff, edge_in;
   logic [gfc_pkg::COUNT_WIDTH-1:0] latched_ff, latched_in;
   logic [gfc_pkg::SAT_WIDTH-1:0]   sat_ff, sat_in;
   logic                            khz_ff, khz_in;
   logic [gfc_pkg::VREF_WIDTH-1:0]  vref_ff, vref_in;

   logic                            accept;
   logic                            done;
   logic [gfc_pkg::GATE_WIDTH-1:0]  tick_next;
   logic [gfc_pkg::COUNT_WIDTH-1:0] edge_base;
   logic [gfc_pkg::COUNT_WIDTH-1:0] fresh_scaled;
   logic [63:0]                     fresh_wide;
   logic [63:0]                     scaled_wide;
   logic [63:0]                     latched_wide;

   assign item_ready = word_ready;
   assign word_valid = item_valid;
   assign accept     = item_valid && word_ready;

   always_comb begin
      tick_next    = tick_ff + 1'b1;
      done         = item_data.tick && (tick_next == gate_ticks);
      edge_base    = done ? '0 : edge_ff;
      fresh_scaled = edge_ff >> 2;
      fresh_wide   = 64'(fresh_scaled);

      tick_in    = tick_ff;
      edge_in    = edge_ff;
      latched_in = latched_ff;
      sat_in     = sat_ff;
      khz_in     = khz_ff;
      vref_in    = vref_ff;

      if (accept) begin
         if (item_data.tick) begin
            tick_in = done ? '0 : tick_next;
         end
         edge_in = edge_base;
         if (item_data.edge_req && (edge_base != gfc_pkg::COUNT_MAX)) begin
            edge_in = edge_base + 1'b1;
         end
         if (done) begin
            latched_in = edge_ff;
            sat_in     = (fresh_wide > 64'(gfc_pkg::DIGIT_LIMIT)) ?
                         gfc_pkg::SAT_WIDTH'(gfc_pkg::DIGIT_LIMIT) :
                         fresh_wide[gfc_pkg::SAT_WIDTH-1:0];
            khz_in     = 64'(edge_ff) > 64'(gfc_pkg::KHZ_LIMIT);
            // Ladder on scaled*10 in steps of 20 reduces to scaled/2.
            if (fresh_wide >= 64'(gfc_pkg::VREF_SAT_AT)) begin
               vref_in = gfc_pkg::VREF_TOP;
            end else if (fresh_wide >= 64'(gfc_pkg::VREF_MIN)) begin
               vref_in = gfc_pkg::VREF_BASE | {4'b0000, fresh_wide[4:1]};
            end
         end
      end

      // The word reports the reading as it stands after this item.
      latched_wide           = 64'(latched_in);
      scaled_wide            = 64'(latched_in >> 2);
      word_data.gate_done    = done;
      word_data.raw_count    = latched_wide[gfc_pkg::RAW_WIDTH-1:0];
      word_data.scaled_value = scaled_wide[gfc_pkg::SCALED_WIDTH-1:0];
      word_data.sat_value    = sat_in;
      word_data.khz_unit     = khz_in;
      word_data.vref_code    = vref_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         edge_ff    <= '0;
         latched_ff <= '0;
         sat_ff     <= '0;
         khz_ff     <= 1'b0;
         vref_ff    <= gfc_pkg::VREF_RESET;
      end else begin
         tick_ff    <= tick_in;
         edge_ff    <= edge_in;
         latched_ff <= latched_in;
         sat_ff     <= sat_in;
         khz_ff     <= khz_in;
         vref_ff    <= vref_in;
      end
   end

endmodule

### rtl/gfc_queue.sv
// Short word queue between the front end and the digit pipeline.
module gfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  gfc_pkg::work_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output gfc_pkg::work_type pop_data,
   input  logic              pop_ready
);

   gfc_pkg::work_type               slot_ff [gfc_pkg::QUEUE_DEPTH];
   logic [gfc_pkg::QPTR_WIDTH-1:0]  wr_ff, wr_in;
   logic [gfc_pkg::QPTR_WIDTH-1:0]  rd_ff, rd_in;
   logic [gfc_pkg::QCNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                            push, pop;

   assign push_ready = cnt_ff != gfc_pkg::QCNT_WIDTH'(gfc_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == gfc_pkg::QPTR_WIDTH'(gfc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == gfc_pkg::QPTR_WIDTH'(gfc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/gfc_back.sv
// Back end: elastic pipeline that splits the saturated value into decimal digits.
module gfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              word_valid,
   input  gfc_pkg::work_type word_data,
   output logic              word_ready,
   output logic              rsp_valid,
   output gfc_pkg::rsp_type  rsp_data,
   input  logic              rsp_ready
);

   localparam int LAST = gfc_pkg::STAGE_COUNT - 1;

   gfc_pkg::stage_type                 stage_ff [gfc_pkg::STAGE_COUNT];
   gfc_pkg::stage_type                 stage_in [gfc_pkg::STAGE_COUNT];
   logic [gfc_pkg::STAGE_COUNT-1:0]    valid_ff, valid_in;
   logic [gfc_pkg::STAGE_COUNT-1:0]    adv;
   gfc_pkg::stage_type                 src;
   gfc_pkg::digit_step_type            step;

   always_comb begin
      // A stage moves when it is empty or the one after it moves.
      adv[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign word_ready = adv[0];

   always_comb begin
      src = '0;
      for (int i = 0; i < gfc_pkg::STAGE_COUNT; i++) begin
         if (i == 0) begin
            src.work   = word_data;
            src.digits = '0;
            src.rem    = word_data.sat_value;
         end else begin
            src = stage_ff[i-1];
         end
         step                                = gfc_pkg::digit_step(src.rem,
                                                                   gfc_pkg::STAGE_WEIGHT[i]);
         stage_in[i]                         = src;
         stage_in[i].digits[LAST + 1 - i]    = step.digit;
         stage_in[i].rem                     = step.rem;
         if (i == LAST) begin
            // What is left below ten is the units digit.
            stage_in[i].digits[0] = step.rem[gfc_pkg::DIGIT_WIDTH-1:0];
         end
         valid_in[i] = valid_ff[i];
         if (adv[i]) begin
            valid_in[i] = (i == 0) ? word_valid : valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < gfc_pkg::STAGE_COUNT; i++) begin
         if (adv[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign rsp_valid                    = valid_ff[LAST];
   assign rsp_data.gate_done           = stage_ff[LAST].work.gate_done;
   assign rsp_data.raw_count           = stage_ff[LAST].work.raw_count;
   assign rsp_data.scaled_value        = stage_ff[LAST].work.scaled_value;
   assign rsp_data.digit_ten_thousands = stage_ff[LAST].digits[4];
   assign rsp_data.digit_thousands     = stage_ff[LAST].digits[3];
   assign rsp_data.digit_hundreds      = stage_ff[LAST].digits[2];
   assign rsp_data.digit_tens          = stage_ff[LAST].digits[1];
   assign rsp_data.digit_units         = stage_ff[LAST].digits[0];
   assign rsp_data.khz_unit            = stage_ff[LAST].work.khz_unit;
   assign rsp_data.vref_code           = stage_ff[LAST].work.vref_code;

endmodule

### rtl/gated_frequency_counter_bcd_unit.sv
// Top level of the gated frequency counter with decimal readout.
//
// Each request word carries a gate-timer tick flag and an input-edge flag and
// yields exactly one response word. Edges are counted over a gate window of
// gate_ticks ticks (reset 5000; the user is to write it through the csr port
// only while idle, which the block does not enforce; zero means 65536 ticks).
// When a tick closes the window the edge count is latched and the counter
// cleared; an edge in that same word counts into the new window, and the edge
// counter saturates. Every response repeats the latest reading: raw count,
// count/4, its five decimal digits saturated at 99999, a kHz flag (raw count
// above 999) and a reference-voltage code 0xE1..0xE9 that holds its value
// when count/4 is below 2 (reset 0xE7); gate_done marks the word that closed
// a window. One word is accepted per clock when the response side keeps up;
// a response word is offered once its request word has passed the counter
// front end, which writes the two-entry queue when the word is accepted, and
// the four-stage digit pipeline (a decimal digit per stage, two in the last).
module gated_frequency_counter_bcd_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gfc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gfc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gfc_pkg::GATE_WIDTH-1:0] csr_data
);

   logic [gfc_pkg::GATE_WIDTH-1:0] gate_ff, gate_in;

   logic              push_valid, push_ready;
   gfc_pkg::work_type push_data;
   logic              pop_valid, pop_ready;
   gfc_pkg::work_type pop_data;

   // Gate length register: always ready, written on every handshake.
   assign csr_ready = 1'b1;
   assign gate_in   = (csr_valid && csr_ready) ? csr_data : gate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= gfc_pkg::GATE_RESET;
      end else begin
         gate_ff <= gate_in;
      end
   end

   // Front end: counters advance in the cycle a request word is accepted.
   gfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid),
      .item_data  (req_data),
      .item_ready (req_ready),
      .gate_ticks (gate_ff),
      .word_valid (push_valid),
      .word_data  (push_data),
      .word_ready (push_ready)
   );

   // Queue: decouple the counters from stalls on the response side.
   gfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Back end: digit extraction, last stage drives the response port.
   gfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (pop_valid),
      .word_data  (pop_data),
      .word_ready (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_ready  (rsp_ready)
   );

endmodule
